// ===== design/deq_pkg.sv =====
package deq_pkg;

	localparam int DEQ_DEPTH = 16;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_PEEK_FRONT = 3'd4;
	localparam logic [2:0] MODE_PEEK_BACK  = 3'd5;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] push_value;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [4:0]         item_count;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_OUT
	} deq_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic capture;
	} deq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_read;
	} deq_stat_t;

endpackage

// ===== design/deq_ram.sv =====
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/deq_ctrl.sv =====
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_cmd_t  cmd
);
	import deq_pkg::*;

	deq_state_t state_q;
	deq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_stall   = 1'b1;
		rsp_valid   = 1'b0;
		cmd.accept  = 1'b0;
		cmd.capture = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = stat.need_read ? ST_READ : ST_OUT;
				end
			end
			ST_READ: begin
				// RAM read data is valid this cycle
				cmd.capture = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				rsp_valid = 1'b1;
				if (!rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/deq_dp.sv =====
module deq_dp #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  deq_pkg::req_item_t req,
	output deq_pkg::rsp_item_t rsp,
	input  deq_pkg::deq_cmd_t  cmd,
	output deq_pkg::deq_stat_t stat
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	rsp_item_t     rsp_q;

	logic          full, empty;
	logic [AW-1:0] front_inc, front_dec, tail_slot, back_slot;
	logic [CW:0]   tail_sum, back_sum, tail_wrap, back_wrap;
	logic [CW-1:0] count_m1;
	logic [CW+4:0] count_ext;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_rdata;
	logic [1:0]    op_status;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;

	// sums stay below twice DEPTH, one subtract wraps them
	assign count_m1  = count_q - 1'b1;
	assign tail_sum  = (CW+1)'(front_q) + (CW+1)'(count_q);
	assign back_sum  = (CW+1)'(front_q) + (CW+1)'(count_m1);
	assign tail_wrap = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;
	assign back_wrap = (back_sum >= (CW+1)'(DEPTH)) ? back_sum - (CW+1)'(DEPTH) : back_sum;
	assign tail_slot = tail_wrap[AW-1:0];
	assign back_slot = back_wrap[AW-1:0];

	always_comb begin
		front_d        = front_q;
		count_d        = count_q;
		ram_we         = 1'b0;
		ram_waddr      = tail_slot;
		ram_raddr      = front_q;
		op_status      = STATUS_OK;
		stat.need_read = 1'b0;
		unique case (req.mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full) begin
					op_status = STATUS_FULL;
				end else begin
					ram_we  = 1'b1;
					count_d = count_q + 1'b1;
					if (req.mode == MODE_PUSH_FRONT) begin
						front_d   = front_dec;
						ram_waddr = front_dec;
					end
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
				if (empty) begin
					op_status = STATUS_EMPTY;
				end else begin
					stat.need_read = 1'b1;
					if (req.mode == MODE_POP_BACK || req.mode == MODE_PEEK_BACK) begin
						ram_raddr = back_slot;
					end
					if (req.mode == MODE_POP_FRONT) begin
						front_d = front_inc;
						count_d = count_m1;
					end else if (req.mode == MODE_POP_BACK) begin
						count_d = count_m1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign count_ext = {5'd0, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rsp_q.read_value <= '0;
			rsp_q.status     <= op_status;
			rsp_q.item_count <= count_ext[4:0];
		end else if (cmd.capture) begin
			rsp_q.read_value <= ram_rdata;
		end
	end

	assign rsp = rsp_q;

	deq_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we & cmd.accept),
		.waddr(ram_waddr),
		.wdata(req.push_value),
		.re   (stat.need_read & cmd.accept),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// ===== design/double_ended_queue_top.sv =====
// channel  direction  payload     handshake
// req      in         req_item_t  req_valid / req_stall
// rsp      out        rsp_item_t  rsp_valid / rsp_stall
//
// One operation at a time. A push or error result is valid the cycle after the
// request transfer; a pop or peek result first passes a read state, in which the
// registered RAM read data is captured. The next request transfers the cycle
// after the result transfers.
// Reset clears front index and count; the entry RAM is not cleared.
// A stalled result holds in the output register.
module double_ended_queue_top #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  deq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output deq_pkg::rsp_item_t rsp
);
	import deq_pkg::*;

	deq_cmd_t  cmd;
	deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	deq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cmd   (cmd),
		.stat  (stat)
	);

endmodule
